// ===== src/sfq_pkg.sv =====
package sfq_pkg;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } sfq_cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [4:0] occupancy;
  } sfq_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } sfq_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic scan;
  } sfq_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic scan_start;
    logic scan_end;
  } sfq_sts_t;

endpackage

// ===== src/searchable_fifo_queue.sv =====
// Searchable FIFO of signed 32-bit values held in a ring of DEPTH RAM entries.
// Issue a beat with start while busy is low; its single result appears on rsp
// for exactly one cycle with done high and must be captured then, since the
// block cannot be stalled. Push, pop and the unused op code raise done in the
// cycle right after the accepting edge, and the next beat can be accepted the
// cycle after done. A search compares m entries (m is the position of the
// first match, or the occupancy when nothing matches, at most DEPTH), read
// through the single read port of the entry RAM one entry per cycle. After
// the last compare the controller moves from ST_SCAN to ST_RESP, raising done. A
// search on an empty queue raises done in the cycle right after the accepting edge.
module searchable_fifo_queue #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sfq_pkg::sfq_cmd_t cmd,
  output logic              busy,
  output logic              done,
  output sfq_pkg::sfq_rsp_t rsp
);

  sfq_pkg::sfq_ctl_t ctl;
  sfq_pkg::sfq_sts_t sts;

  sfq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .sts  (sts),
    .ctl  (ctl),
    .busy (busy),
    .done (done)
  );

  sfq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .ctl(ctl),
    .sts(sts),
    .rsp(rsp)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("block not idle after result");

  a_scan_done: assert property (@(posedge clk) disable iff (rst)
    (ctl.scan && sts.scan_end) |=> done)
    else $error("search end not followed by result");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status == sfq_pkg::STAT_FULL)) |-> (rsp.occupancy == 5'(DEPTH)))
    else $error("full status with queue not full");

endmodule

// ===== src/sfq_ram.sv =====
module sfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sfq_ctrl.sv =====
module sfq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sfq_pkg::sfq_sts_t sts,
  output sfq_pkg::sfq_ctl_t ctl,
  output logic              busy,
  output logic              done
);

  sfq_pkg::sfq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sfq_pkg::ST_IDLE: begin
        if (start) begin
          state_next = sts.scan_start ? sfq_pkg::ST_SCAN : sfq_pkg::ST_RESP;
        end
      end
      sfq_pkg::ST_SCAN: begin
        if (sts.scan_end) begin
          state_next = sfq_pkg::ST_RESP;
        end
      end
      sfq_pkg::ST_RESP: state_next = sfq_pkg::ST_IDLE;
      default:          state_next = sfq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.accept = 1'b0;
    ctl.scan   = 1'b0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      sfq_pkg::ST_IDLE: begin
        busy       = 1'b0;
        ctl.accept = start;
      end
      sfq_pkg::ST_SCAN: ctl.scan = 1'b1;
      sfq_pkg::ST_RESP: done = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

// ===== src/sfq_dp.sv =====
module sfq_dp #(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  sfq_pkg::sfq_cmd_t cmd,
  input  sfq_pkg::sfq_ctl_t ctl,
  output sfq_pkg::sfq_sts_t sts,
  output sfq_pkg::sfq_rsp_t rsp
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [AW-1:0] head, tail, ptr;
  logic [CW-1:0] count, issue_left, cmp_left;
  logic          rd_valid;
  logic [31:0]   value;
  logic [31:0]   rdata;
  logic          found;
  logic [1:0]    status;
  logic          we;
  logic          hit;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
    return (idx == LAST) ? '0 : idx + AW'(1);
  endfunction

  assign we  = ctl.accept && (cmd.op == sfq_pkg::OP_PUSH) && (count != FULL_COUNT);
  assign hit = rd_valid && (rdata == value);

  sfq_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(tail),
    .wdata(cmd.value),
    .raddr(ptr),
    .rdata(rdata)
  );

  assign sts.scan_start = (cmd.op == sfq_pkg::OP_SEARCH) && (count != '0);
  // stop on the first match or after the last held entry is compared
  assign sts.scan_end   = rd_valid && (hit || (cmp_left == CW'(1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      rd_valid <= 1'b0;
    end else if (ctl.accept) begin
      rd_valid <= 1'b0;
      case (cmd.op)
        sfq_pkg::OP_PUSH: begin
          if (count != FULL_COUNT) begin
            tail  <= ring_next(tail);
            count <= count + CW'(1);
          end
        end
        sfq_pkg::OP_POP: begin
          if (count != '0) begin
            head  <= ring_next(head);
            count <= count - CW'(1);
          end
        end
        default: ;
      endcase
    end else if (ctl.scan) begin
      rd_valid <= (issue_left != '0);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      value      <= cmd.value;
      found      <= 1'b0;
      ptr        <= head;
      issue_left <= count;
      cmp_left   <= count;
      case (cmd.op)
        sfq_pkg::OP_PUSH: status <= (count == FULL_COUNT) ? sfq_pkg::STAT_FULL
                                                          : sfq_pkg::STAT_DONE;
        sfq_pkg::OP_POP:  status <= (count == '0) ? sfq_pkg::STAT_EMPTY
                                                  : sfq_pkg::STAT_DONE;
        default:          status <= sfq_pkg::STAT_DONE;
      endcase
    end else if (ctl.scan) begin
      // advance the read pointer one entry a cycle, compare the beat read last cycle
      if (issue_left != '0) begin
        ptr        <= ring_next(ptr);
        issue_left <= issue_left - CW'(1);
      end
      if (rd_valid) begin
        cmp_left <= cmp_left - CW'(1);
      end
      if (hit) begin
        found <= 1'b1;
      end
    end
  end

  assign rsp.status    = status;
  assign rsp.found     = found;
  assign rsp.occupancy = 5'(count);

endmodule
